// ===== rtl/lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared widths, character constants, dictionary entry type and root entry
// function for the LZW stream decoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

	localparam int CODE_W        = 12;
	localparam int CHAR_W        = 8;
	localparam int LEN_W         = 7;
	localparam int ROOT_COUNT    = 27;
	localparam int DICT_SIZE_DEF = 4096;
	localparam int MAX_LEN_DEF   = 64;

	localparam logic [CHAR_W-1:0] CHAR_HASH = 8'h23;
	localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;

	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [CHAR_W-1:0] tail;
		logic [CHAR_W-1:0] head;
		logic [LEN_W-1:0]  len;
	} dict_entry_t;

	// root entries are never stored: '#' for code 0, 'A'..'Z' for 1..26
	function automatic dict_entry_t root_entry(input logic [CODE_W-1:0] code);
		dict_entry_t       e;
		logic [CHAR_W-1:0] ch;
		if (code == '0) begin
			ch = CHAR_HASH;
		end else begin
			ch = CHAR_W'(CHAR_A + CHAR_W'(code) - CHAR_W'(1));
		end
		e.prefix = '0;
		e.tail   = ch;
		e.head   = ch;
		e.len    = LEN_W'(1);
		return e;
	endfunction

endpackage

// ===== rtl/lzw_ram.sv =====
// ----------------------------------------------------------------------------
// lzw_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lzw_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// lzw_stream_decoder
// LZW decoder over a 27-symbol root alphabet ('#', 'A'..'Z'); one code word
// in, that code's string out one byte per word, last byte marked.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields (low bit up)                     | word accepted
//  --------+-----+-----------------------------------------+------------------------
//  s_*     | in  | tdata: code_word[11:0]; tuser: start    | s_tvalid & s_tready
//  m_*     | out | tdata: out_byte[7:0]; tlast: last_byte; | m_tvalid & m_tready
//          |     | tuser: bad_code                         |
//
// Steps: a code of string length L is accepted, its entry is looked up in the
// dictionary RAM, the prefix chain is walked (one RAM read per link), the byte
// stack read is primed, then L bytes go out at one per cycle while m_tready
// allows. A rejected code goes through S_ERR and emits one bad_code word.
// Reset: state, next-free pointer and history flag clear at once; the
// dictionary RAM needs no clearing since only entries below next_free are read.
// Stalls: s_tready is high only between codes; m_tready low holds the output
// word and pauses the byte stream.
// ----------------------------------------------------------------------------
module lzw_stream_decoder
	import lzw_pkg::*;
#(
	parameter int DICT_SIZE = DICT_SIZE_DEF,
	parameter int MAX_LEN   = MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // code_word[11:0], zero pad
	input  logic [0:0]  s_tuser,   // stream_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast,   // last_byte
	output logic [0:0]  m_tuser    // bad_code
);

	localparam int AW   = $clog2(DICT_SIZE);
	localparam int NFW  = $clog2(DICT_SIZE + 1);
	localparam int CMPW = (NFW > CODE_W) ? NFW : CODE_W;
	localparam int SW   = $clog2(MAX_LEN);
	localparam int EW   = $bits(dict_entry_t);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOOK = 6'b000010,
		S_WALK = 6'b000100,
		S_RD   = 6'b001000,
		S_OUT  = 6'b010000,
		S_ERR  = 6'b100000
	} state_t;

	state_t state_q;

	// dictionary history
	logic [NFW-1:0]    nf_q;
	logic              have_q;
	logic [CODE_W-1:0] prev_code_q;
	logic [LEN_W-1:0]  prev_len_q;
	logic [CHAR_W-1:0] prev_head_q;

	// per-code work registers
	logic [CODE_W-1:0] code_q;
	logic [CODE_W-1:0] k_q;      // chain address being read
	logic              grow_q;
	logic              kwk_q;    // code equals next free entry
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  pos_q;    // chars still to push
	logic [LEN_W-1:0]  ep_q;     // emit position

	// output register
	logic              ov_q;
	logic [CHAR_W-1:0] obyte_q;
	logic              olast_q;
	logic              obad_q;

	// RAM ports
	logic              dict_we;
	logic [AW-1:0]     dict_waddr;
	logic [AW-1:0]     dict_raddr;
	logic [EW-1:0]     dict_rdata;
	logic              stk_we;
	logic [SW-1:0]     stk_waddr;
	logic [SW-1:0]     stk_raddr;
	logic [CHAR_W-1:0] stk_rdata;

	// decode of the accepted word
	logic [CODE_W-1:0] in_code;
	logic              in_start;
	logic              accept;
	logic [NFW-1:0]    eff_nf;
	logic              eff_have;
	logic              can_grow;
	logic [CMPW-1:0]   code_x;
	logic [CMPW-1:0]   nf_x;
	logic              reject;

	// lookup and walk
	dict_entry_t       ent_rd;
	dict_entry_t       new_ent;
	dict_entry_t       cur;
	logic [CHAR_W-1:0] first_ch;
	logic              out_free;
	logic              emit_load;
	logic              emit_last;
	logic              out_load;

	assign in_code  = s_tdata[CODE_W-1:0];
	assign in_start = s_tuser[0];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// stream start cuts the dictionary back before this code is judged
	always_comb begin
		eff_nf   = in_start ? NFW'(ROOT_COUNT) : nf_q;
		eff_have = in_start ? 1'b0 : have_q;
		can_grow = eff_have && (eff_nf < NFW'(DICT_SIZE)) && (prev_len_q < LEN_W'(MAX_LEN));
		code_x   = CMPW'(in_code);
		nf_x     = CMPW'(eff_nf);
		reject   = (code_x > nf_x) || (code_x >= CMPW'(DICT_SIZE)) ||
		           ((code_x == nf_x) && !can_grow);
	end

	// entry at k_q: roots come from logic, the rest from the RAM
	always_comb begin
		if (k_q < CODE_W'(ROOT_COUNT)) begin
			ent_rd = root_entry(k_q);
		end else begin
			ent_rd = dict_entry_t'(dict_rdata);
		end
		first_ch       = kwk_q ? prev_head_q : ent_rd.head;
		new_ent.prefix = prev_code_q;
		new_ent.tail   = first_ch;
		new_ent.head   = prev_head_q;
		new_ent.len    = prev_len_q + LEN_W'(1);
		// KwKwK: the entry being written this cycle is forwarded
		cur            = kwk_q ? new_ent : ent_rd;
	end

	assign out_free  = !ov_q || m_tready;
	assign emit_last = (ep_q == len_q - LEN_W'(1));
	assign emit_load = (state_q == S_OUT) && out_free;
	assign out_load  = emit_load || ((state_q == S_ERR) && out_free);

	// RAM address and write control
	always_comb begin
		dict_we    = (state_q == S_LOOK) && grow_q;
		dict_waddr = AW'(nf_q);
		stk_we     = 1'b0;
		stk_waddr  = '0;
		case (state_q)
			S_IDLE:  dict_raddr = AW'(in_code);
			S_LOOK:  dict_raddr = AW'(cur.prefix);
			S_WALK:  dict_raddr = AW'(ent_rd.prefix);
			default: dict_raddr = AW'(k_q);
		endcase
		case (state_q)
			S_LOOK: begin
				stk_we    = 1'b1;
				stk_waddr = SW'(cur.len - LEN_W'(1));
			end
			S_WALK: begin
				stk_we    = 1'b1;
				stk_waddr = SW'(pos_q - LEN_W'(1));
			end
			default: begin
				stk_we    = 1'b0;
				stk_waddr = '0;
			end
		endcase
		stk_raddr = emit_load ? SW'(ep_q + LEN_W'(1)) : SW'(ep_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nf_q    <= NFW'(ROOT_COUNT);
			have_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						nf_q   <= eff_nf;
						have_q <= eff_have;
						code_q <= in_code;
						k_q    <= in_code;
						grow_q <= can_grow;
						kwk_q  <= (code_x == nf_x);
						state_q <= reject ? S_ERR : S_LOOK;
					end
				end
				S_LOOK: begin
					if (grow_q) begin
						nf_q <= nf_q + NFW'(1);
					end
					prev_code_q <= code_q;
					prev_len_q  <= cur.len;
					prev_head_q <= cur.head;
					have_q      <= 1'b1;
					// chain links below the new entry come from the RAM or the root logic
					kwk_q       <= 1'b0;
					len_q       <= cur.len;
					pos_q       <= cur.len - LEN_W'(1);
					k_q         <= cur.prefix;
					ep_q        <= '0;
					state_q     <= (cur.len == LEN_W'(1)) ? S_RD : S_WALK;
				end
				S_WALK: begin
					pos_q <= pos_q - LEN_W'(1);
					k_q   <= ent_rd.prefix;
					if (pos_q == LEN_W'(1)) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (emit_load) begin
						obyte_q <= stk_rdata;
						olast_q <= emit_last;
						obad_q  <= 1'b0;
						ep_q    <= ep_q + LEN_W'(1);
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						obyte_q <= '0;
						olast_q <= 1'b0;
						obad_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = ov_q;
	assign m_tdata    = obyte_q;
	assign m_tlast    = olast_q;
	assign m_tuser[0] = obad_q;

	// dictionary: prefix, tail, head, length per entry
	lzw_ram #(
		.WIDTH(EW),
		.DEPTH(DICT_SIZE)
	) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata (EW'(new_ent)),
		.raddr (dict_raddr),
		.rdata (dict_rdata)
	);

	// reversal stack for the chain walk
	lzw_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_LEN)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (cur.tail),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

endmodule
